/* rtl/core/serial_rx_ring_with_newline_map_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the serial receive ring block
// Clocked assertion forms with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef SERIAL_RX_RING_WITH_NEWLINE_MAP_ASSERT_SVH
`define SERIAL_RX_RING_WITH_NEWLINE_MAP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Assertion that is held off while reset is low
`define SRX_ASSERT_RST(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);
// Assertion that is checked at every edge
`define SRX_ASSERT_ALW(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define SRX_ASSERT_RST(lbl, clk_s, rstn_s, prop, msg)
`define SRX_ASSERT_ALW(lbl, clk_s, prop, msg)
`endif

`endif

/* rtl/core/srx_pkg.sv */
// ----------------------------------------------------------------------------
// srx_pkg
// Shared codes, constants and the decode result type of the receive ring.
// ----------------------------------------------------------------------------
`default_nettype none

package srx_pkg;

  localparam int RING_DEPTH_DEF = 64;
  localparam int FILL_W         = 6;

  // input function codes
  localparam logic [1:0] FUNC_RX   = 2'd0;
  localparam logic [1:0] FUNC_READ = 2'd1;
  localparam logic [1:0] FUNC_TX   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_RX   = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_TX   = 2'd2;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef struct packed {
    logic              load;      // transaction produces a result
    logic              split;     // transmit line feed: CR then LF
    logic              from_mem;  // byte comes from the ring read port
    logic [1:0]        kind;
    logic [7:0]        data_v;
    logic              empty;
    logic              dropped;
    logic              discarded;
    logic [FILL_W-1:0] fill;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/srx_ring_mem.sv */
// ----------------------------------------------------------------------------
// srx_ring_mem
// Ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module srx_ring_mem #(
  parameter int RING_DEPTH = 64,
  parameter int AW         = 6
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_q
);

  logic [7:0] mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold the read data until the next pop
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/srx_ring_ptr.sv */
// ----------------------------------------------------------------------------
// srx_ring_ptr
// Decodes a transaction, maps newlines and keeps the ring indices and count.
// ----------------------------------------------------------------------------
`default_nettype none

`include "serial_rx_ring_with_newline_map_assert.svh"

module srx_ring_ptr
  import srx_pkg::*;
#(
  parameter int RING_DEPTH = 64,
  parameter int AW         = 6
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_acc,
  input  wire logic [1:0]    in_func,
  input  wire logic [7:0]    in_data_byte,
  output res_t               res,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [7:0]         wr_data,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr
);

  localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          wr_c, rd_c;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + AW'(1);
  endfunction

  always_comb begin
    wr_c       = 1'b0;
    rd_c       = 1'b0;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    res        = '0;
    unique case (in_func)
      FUNC_RX: begin
        res.load = 1'b1;
        res.kind = KIND_RX;
        if (in_data_byte == CH_LF) begin
          res.discarded = 1'b1;
        end else if (cnt_r == LAST_IDX) begin
          res.dropped = 1'b1;
        end else begin
          wr_c       = 1'b1;
          wr_ptr_nxt = adv(wr_ptr_r);
          cnt_nxt    = cnt_r + AW'(1);
        end
      end
      FUNC_READ: begin
        res.load = 1'b1;
        res.kind = KIND_READ;
        if (cnt_r == '0) begin
          res.empty = 1'b1;
        end else begin
          rd_c         = 1'b1;
          res.from_mem = 1'b1;
          rd_ptr_nxt   = adv(rd_ptr_r);
          cnt_nxt      = cnt_r - AW'(1);
        end
      end
      FUNC_TX: begin
        res.load   = 1'b1;
        res.kind   = KIND_TX;
        res.split  = (in_data_byte == CH_LF);
        res.data_v = (in_data_byte == CH_LF) ? CH_CR : in_data_byte;
      end
      default: begin
        // unused code: no result, no state change
      end
    endcase
    res.fill = FILL_W'(cnt_nxt);
  end

  assign wr_en   = in_acc & wr_c;
  assign wr_addr = wr_ptr_r;
  assign wr_data = (in_data_byte == CH_CR) ? CH_LF : in_data_byte;
  assign rd_en   = in_acc & rd_c;
  assign rd_addr = rd_ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else if (in_acc) begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `SRX_ASSERT_RST(a_cnt_bound, clk, rst_n, cnt_r <= LAST_IDX, "ring count above capacity")
  `SRX_ASSERT_RST(a_rd_nonempty, clk, rst_n, rd_en |-> (cnt_r != '0), "pop from empty ring")
  `SRX_ASSERT_RST(a_wr_gap, clk, rst_n, wr_en |=> (wr_ptr_r != rd_ptr_r), "write filled last slot")

endmodule

`default_nettype wire

/* rtl/core/srx_out_stage.sv */
// ----------------------------------------------------------------------------
// srx_out_stage
// Result register; expands a transmitted line feed into two results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "serial_rx_ring_with_newline_map_assert.svh"

module srx_out_stage
  import srx_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire res_t              res,
  input  wire logic [7:0]        mem_q,
  input  wire logic              out_stall,
  output logic                   busy,
  output logic                   out_valid,
  output logic [1:0]             out_result_kind,
  output logic [7:0]             out_out_byte,
  output logic                   out_buffer_empty,
  output logic                   out_byte_dropped,
  output logic                   out_byte_discarded,
  output logic [FILL_W-1:0]      out_fill_count,
  output logic                   out_last
);

  logic              valid_r;
  logic              pend_r;
  logic              from_mem_r;
  logic [1:0]        kind_r;
  logic [7:0]        data_r;
  logic              empty_r, dropped_r, discarded_r, last_r;
  logic [FILL_W-1:0] fill_r;
  logic              take;

  assign take = valid_r & ~out_stall;
  assign busy = pend_r | (valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
      pend_r  <= res.split;
    end else if (take) begin
      valid_r <= pend_r;
      pend_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      from_mem_r  <= res.from_mem;
      kind_r      <= res.kind;
      data_r      <= res.data_v;
      empty_r     <= res.empty;
      dropped_r   <= res.dropped;
      discarded_r <= res.discarded;
      fill_r      <= res.fill;
      last_r      <= ~res.split;
    end else if (take && pend_r) begin
      // second half of an expanded line feed
      data_r <= CH_LF;
      last_r <= 1'b1;
    end
  end

  assign out_valid          = valid_r;
  assign out_result_kind    = kind_r;
  assign out_out_byte       = from_mem_r ? mem_q : data_r;
  assign out_buffer_empty   = empty_r;
  assign out_byte_dropped   = dropped_r;
  assign out_byte_discarded = discarded_r;
  assign out_fill_count     = fill_r;
  assign out_last           = last_r;

  `SRX_ASSERT_RST(a_pend_valid, clk, rst_n, pend_r |-> valid_r, "pending half without result")
  `SRX_ASSERT_RST(a_pend_cr, clk, rst_n, pend_r |-> (data_r == CH_CR && !last_r && !from_mem_r),
                  "pending half without leading CR")
  `SRX_ASSERT_RST(a_load_free, clk, rst_n, load |-> !busy, "load while result register busy")

endmodule

`default_nettype wire

/* rtl/core/serial_rx_ring_with_newline_map.sv */
// ----------------------------------------------------------------------------
// serial_rx_ring_with_newline_map
// Receive ring buffer with CR/LF mapping and transmit newline expansion.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries in_func and in_data_byte:
//   received byte, read request or byte to transmit. Unused func code 3 is
//   accepted and produces nothing.
//   Result channel (out_valid/out_stall) carries one result per transaction,
//   two for a transmitted line feed (CR with out_last low, then LF).
//   Latency: a result is presented the cycle after its input is accepted;
//   read data comes straight from the ring's registered read port.
//   Throughput: one transaction per cycle while results are taken; a
//   transmitted line feed occupies the result register until both results are taken.
//   in_stall is high while the result register holds a result that the
//   receiver stalls, and while the second half of a line feed is pending.
//   Reset clears the ring indices and fill count; ring contents need no
//   clearing, so the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_rx_ring_with_newline_map
  import srx_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_func,
  input  wire logic [7:0]        in_data_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_result_kind,
  output logic [7:0]             out_out_byte,
  output logic                   out_buffer_empty,
  output logic                   out_byte_dropped,
  output logic                   out_byte_discarded,
  output logic [FILL_W-1:0]      out_fill_count,
  output logic                   out_last
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  res_t          res;
  logic          in_acc;
  logic          busy;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, mem_q;

  assign in_stall = busy;
  assign in_acc   = in_valid & ~busy;

  srx_ring_ptr #(
    .RING_DEPTH (RING_DEPTH),
    .AW         (AW)
  ) u_ptr (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_acc       (in_acc),
    .in_func      (in_func),
    .in_data_byte (in_data_byte),
    .res          (res),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr)
  );

  srx_ring_mem #(
    .RING_DEPTH (RING_DEPTH),
    .AW         (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_q    (mem_q)
  );

  srx_out_stage u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (in_acc & res.load),
    .res                (res),
    .mem_q              (mem_q),
    .out_stall          (out_stall),
    .busy               (busy),
    .out_valid          (out_valid),
    .out_result_kind    (out_result_kind),
    .out_out_byte       (out_out_byte),
    .out_buffer_empty   (out_buffer_empty),
    .out_byte_dropped   (out_byte_dropped),
    .out_byte_discarded (out_byte_discarded),
    .out_fill_count     (out_fill_count),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire
